### hw/rtl/rect_to_polar_converter_top_defines.svh
// Assertion macros for the rectangular to polar converter
`ifndef RECT_TO_POLAR_CONVERTER_TOP_DEFINES_SVH
`define RECT_TO_POLAR_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTP_ASSERT_IMPL(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("rtp assertion failed");

// next-cycle implication, also checked across reset
`define RTP_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) (lhs) |=> (rhs)) \
      else $error("rtp assertion failed");

`endif

### hw/rtl/rtp_pkg.sv
package rtp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int ITERATIONS  = 16;
   localparam int TABLE_LEN   = 32;
   localparam int NUM_CELLS   = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
   localparam int GUARD_SHIFT = 16;
   localparam int DATA_W      = COORD_WIDTH + GUARD_SHIFT + 4;
   localparam int ANGLE_ACC_W = 32;
   localparam int ANGLE_W     = 16;
   localparam int SHIFT_W     = $clog2(TABLE_LEN);
   localparam int GAIN_W      = 32;
   localparam int LO_W        = DATA_W / 2;
   localparam int HI_W        = DATA_W - LO_W;
   localparam int PROD_W      = DATA_W + GAIN_W;
   localparam int RAD_SHIFT   = GUARD_SHIFT + GAIN_W;
   localparam int RAD_FULL_W  = PROD_W - RAD_SHIFT;

   localparam logic [GAIN_W-1:0] INV_GAIN = 32'h9B74EDA8;
   localparam logic [ANGLE_ACC_W-1:0] HALF_PI_POS = 32'h4000_0000;
   localparam logic [ANGLE_ACC_W-1:0] HALF_PI_NEG = 32'hC000_0000;

   localparam logic [ANGLE_ACC_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [ANGLE_ACC_W-1:0]   z;
   } stage_type;

endpackage

### hw/rtl/rtp_pre.sv
module rtp_pre (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [rtp_pkg::COORD_WIDTH-1:0] in_x,
   input  logic signed [rtp_pkg::COORD_WIDTH-1:0] in_y,
   output rtp_pkg::stage_type                   out_stage
);

   localparam int DW = rtp_pkg::DATA_W;
   localparam int GS = rtp_pkg::GUARD_SHIFT;

   rtp_pkg::stage_type stage_ff, stage_in;
   logic signed [DW-1:0] x_ext, y_ext, x_rot, y_rot;
   logic [rtp_pkg::ANGLE_ACC_W-1:0] z_rot;

   always_comb begin
      x_ext = DW'(in_x);
      y_ext = DW'(in_y);
      x_rot = x_ext;
      y_rot = y_ext;
      z_rot = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_rot = y_ext;
            y_rot = -x_ext;
            z_rot = rtp_pkg::HALF_PI_POS;
         end else begin
            x_rot = -y_ext;
            y_rot = x_ext;
            z_rot = rtp_pkg::HALF_PI_NEG;
         end
      end
      stage_in.valid = in_valid;
      stage_in.zero  = (in_x == 0) && (in_y == 0);
      stage_in.x     = {x_rot[DW-GS-1:0], {GS{1'b0}}};
      stage_in.y     = {y_rot[DW-GS-1:0], {GS{1'b0}}};
      stage_in.z     = z_rot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.zero <= stage_in.zero;
         stage_ff.x    <= stage_in.x;
         stage_ff.y    <= stage_in.y;
         stage_ff.z    <= stage_in.z;
      end
   end

   assign out_stage = stage_ff;

endmodule

### hw/rtl/rtp_cell.sv
module rtp_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [rtp_pkg::SHIFT_W-1:0]        shift,
   input  logic [rtp_pkg::ANGLE_ACC_W-1:0]    atan_step,
   input  rtp_pkg::stage_type                 in_stage,
   output rtp_pkg::stage_type                 out_stage
);

   rtp_pkg::stage_type stage_ff, stage_in;
   logic signed [rtp_pkg::DATA_W-1:0] xs, ys;

   // one vectoring micro-rotation, drives y toward zero
   always_comb begin
      xs = in_stage.x >>> shift;
      ys = in_stage.y >>> shift;
      stage_in = in_stage;
      if (!in_stage.y[rtp_pkg::DATA_W-1]) begin
         stage_in.x = in_stage.x + ys;
         stage_in.y = in_stage.y - xs;
         stage_in.z = in_stage.z + atan_step;
      end else begin
         stage_in.x = in_stage.x - ys;
         stage_in.y = in_stage.y + xs;
         stage_in.z = in_stage.z - atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.zero <= stage_in.zero;
         stage_ff.x    <= stage_in.x;
         stage_ff.y    <= stage_in.y;
         stage_ff.z    <= stage_in.z;
      end
   end

   assign out_stage = stage_ff;

endmodule

### hw/rtl/rtp_gain.sv
module rtp_gain (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  rtp_pkg::stage_type                 in_stage,
   output logic                               out_valid,
   output logic [rtp_pkg::COORD_WIDTH-1:0]    out_radius,
   output logic signed [rtp_pkg::ANGLE_W-1:0] out_angle
);

   localparam int DW = rtp_pkg::DATA_W;
   localparam int CW = rtp_pkg::COORD_WIDTH;
   localparam int AW = rtp_pkg::ANGLE_W;
   localparam int PW = rtp_pkg::PROD_W;
   localparam int LW = rtp_pkg::LO_W;
   localparam int HW = rtp_pkg::HI_W;
   localparam int GW = rtp_pkg::GAIN_W;
   localparam int RS = rtp_pkg::RAD_SHIFT;
   localparam int RW = rtp_pkg::RAD_FULL_W;
   localparam logic [PW-1:0] ROUND_BIT = PW'(1) << (RS - 1);
   localparam logic [rtp_pkg::ANGLE_ACC_W-1:0] ANGLE_HALF =
      rtp_pkg::ANGLE_ACC_W'(1) << (rtp_pkg::ANGLE_ACC_W - AW - 1);

   // stage a: partial products of x times inverse gain
   logic                 valid_a_ff, valid_a_in;
   logic                 zero_a_ff;
   logic [HW+GW-1:0]     p_hi_ff, p_hi_in;
   logic [LW+GW-1:0]     p_lo_ff, p_lo_in;
   logic [AW-1:0]        angle_a_ff, angle_a_in;
   logic [DW-1:0]        xm;
   logic [rtp_pkg::ANGLE_ACC_W-1:0] z_round;

   // stage b: sum, round, saturate
   logic                 valid_ff, valid_in;
   logic [CW-1:0]        radius_ff, radius_in;
   logic [AW-1:0]        angle_ff, angle_in;
   logic [PW-1:0]        sum;
   logic [RW-1:0]        rad_full;

   always_comb begin
      xm         = in_stage.x[DW-1] ? '0 : DW'(in_stage.x);
      p_hi_in    = (HW+GW)'(xm[DW-1:LW]) * (HW+GW)'(rtp_pkg::INV_GAIN);
      p_lo_in    = (LW+GW)'(xm[LW-1:0]) * (LW+GW)'(rtp_pkg::INV_GAIN);
      z_round    = in_stage.z + ANGLE_HALF;
      angle_a_in = in_stage.zero ? '0 : z_round[rtp_pkg::ANGLE_ACC_W-1 -: AW];
      valid_a_in = in_stage.valid;
   end

   always_comb begin
      sum       = (PW'(p_hi_ff) << LW) + PW'(p_lo_ff) + ROUND_BIT;
      rad_full  = sum[PW-1:RS];
      radius_in = '0;
      if (!zero_a_ff) begin
         radius_in = (rad_full[RW-1:CW] != '0) ? '1 : rad_full[CW-1:0];
      end
      angle_in = angle_a_ff;
      valid_in = valid_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= valid_a_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_a_ff  <= in_stage.zero;
         p_hi_ff    <= p_hi_in;
         p_lo_ff    <= p_lo_in;
         angle_a_ff <= angle_a_in;
         radius_ff  <= radius_in;
         angle_ff   <= angle_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_radius = radius_ff;
   assign out_angle  = angle_ff;

endmodule

### hw/rtl/rect_to_polar_converter_top.sv
// Rectangular to polar converter, CORDIC vectoring mode.
// Request channel: req_valid/req_ready with signed req_x_coord, req_y_coord.
// Response channel: rsp_valid/rsp_ready with unsigned rsp_radius (rounded,
// gain corrected, saturating) and signed rsp_angle (32768 = pi, wraps).
// Every request word gives exactly one response word, in order.
// Pipeline: one quadrant fold stage, one cell per iteration, one partial
// product stage and one output register.
// Throughput: one word per cycle unless stalled; the chain of cells
// advances as a whole.
// Stall: when rsp_valid is high and rsp_ready low the whole chain holds,
// req_ready drops in the same cycle and no word is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, the block is
// empty and ready on the first cycle after reset.
// The origin gives radius 0 and angle 0.
`include "rect_to_polar_converter_top_defines.svh"

module rect_to_polar_converter_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rtp_pkg::COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [rtp_pkg::COORD_WIDTH-1:0] req_y_coord,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rtp_pkg::COORD_WIDTH-1:0]        rsp_radius,
   output logic signed [rtp_pkg::ANGLE_W-1:0]     rsp_angle
);

   logic advance;
   rtp_pkg::stage_type chain [rtp_pkg::NUM_CELLS+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   rtp_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_x      (req_x_coord),
      .in_y      (req_y_coord),
      .out_stage (chain[0])
   );

   for (genvar i = 0; i < rtp_pkg::NUM_CELLS; i++) begin : g_cell
      rtp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .shift     (rtp_pkg::SHIFT_W'(i)),
         .atan_step (rtp_pkg::ATAN_TABLE[i]),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   rtp_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_stage   (chain[rtp_pkg::NUM_CELLS]),
      .out_valid  (rsp_valid),
      .out_radius (rsp_radius),
      .out_angle  (rsp_angle)
   );

   `RTP_ASSERT_NEXT(a_reset_empties, reset, !rsp_valid)
   `RTP_ASSERT_IMPL(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)
   `RTP_ASSERT_NEXT(a_chain_holds, !reset && !req_ready, $stable(chain[rtp_pkg::NUM_CELLS]))

endmodule

### tb/rect_to_polar_converter_top_tb.sv
module rect_to_polar_converter_top_tb;

   localparam int CW = rtp_pkg::COORD_WIDTH;
   localparam int AW = rtp_pkg::ANGLE_W;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } point_type;

   typedef struct {
      logic [CW-1:0]        radius;
      logic signed [AW-1:0] angle;
   } polar_type;

   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CALM_WORDS       = 150;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_x_coord = '0;
   logic signed [CW-1:0] req_y_coord = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [CW-1:0]        rsp_radius;
   logic signed [AW-1:0] rsp_angle;

   point_type points_pending[$];
   polar_type polar_due[$];

   int words_in      = 0;
   int words_out     = 0;
   int words_offered = 0;
   int total_words   = 0;
   int errors        = 0;
   int send_gap      = 0;
   int hold_cnt      = 0;
   bit long_hold_done = 1'b0;

   rect_to_polar_converter_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_radius  (rsp_radius),
      .rsp_angle   (rsp_angle)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // CORDIC vectoring: fold to right half plane, micro-rotate, gain-correct
   function automatic polar_type polar_of(logic signed [CW-1:0] xc,
                                          logic signed [CW-1:0] yc);
      longint      x;
      longint      y;
      longint      z;
      longint      t;
      longint      xs;
      longint      ys;
      longint      ang;
      logic [127:0] xm;
      logic [127:0] prod;
      logic [127:0] rad;
      polar_type   r;
      x = xc;
      y = yc;
      z = 0;
      if (x == 0 && y == 0) begin
         r.radius = '0;
         r.angle  = '0;
         return r;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = longint'(rtp_pkg::HALF_PI_POS);
         end else begin
            t = x; x = -y; y = t; z = -longint'(rtp_pkg::HALF_PI_POS);
         end
      end
      x = x <<< rtp_pkg::GUARD_SHIFT;
      y = y <<< rtp_pkg::GUARD_SHIFT;
      for (int i = 0; i < rtp_pkg::NUM_CELLS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(rtp_pkg::ATAN_TABLE[i]);
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(rtp_pkg::ATAN_TABLE[i]);
         end
      end
      xm   = (x < 0) ? 128'd0 : 128'(x);
      prod = xm * 128'(rtp_pkg::INV_GAIN) + (128'd1 << 47);
      rad  = prod >> 48;
      r.radius = (rad > 128'((1 << CW) - 1)) ? '1 : rad[CW-1:0];
      ang = (z + 64'sd32768) >>> 16;
      r.angle = ang[AW-1:0];
      return r;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      return CW'($urandom());
   endfunction

   function automatic logic signed [CW-1:0] edge_coord();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return -32767;
         2: return 32767;
         3: return 32766;
         default: return rand_coord();
      endcase
   endfunction

   function automatic logic signed [CW-1:0] small_coord();
      return CW'(int'($urandom_range(0, 16)) - 8);
   endfunction

   task automatic add_point(input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y);
      point_type p;
      p.x = x;
      p.y = y;
      points_pending.push_back(p);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      logic      free;
      logic      calm;
      point_type p;
      if (!reset) begin
         free = !req_valid || (words_in == words_offered);
         calm = words_in > total_words - CALM_WORDS;
         if (free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (points_pending.size() > 0) begin
               p = points_pending.pop_front();
               req_valid   <= 1'b1;
               req_x_coord <= p.x;
               req_y_coord <= p.y;
               words_offered++;
               if (!calm && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with one long hold to fill the chain
   always @(negedge clock) begin : drive_rsp
      logic calm;
      if (!reset) begin
         calm = words_in > total_words - CALM_WORDS;
         if (!long_hold_done && words_in >= LONG_HOLD_AT) begin
            hold_cnt       = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      polar_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            polar_due.push_back(polar_of(req_x_coord, req_y_coord));
            words_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (polar_due.size() == 0) begin
               $display("%0t: unexpected word radius %0d angle %0d",
                        $time, rsp_radius, rsp_angle);
               errors++;
            end else begin
               want = polar_due.pop_front();
               if (rsp_radius !== want.radius) begin
                  $display("%0t: radius mismatch expected %0d actual %0d",
                           $time, want.radius, rsp_radius);
                  errors++;
               end
               if (rsp_angle !== want.angle) begin
                  $display("%0t: angle mismatch expected %0d actual %0d",
                           $time, want.angle, rsp_angle);
                  errors++;
               end
            end
            words_out++;
         end
      end
   end

   initial begin
      logic signed [CW-1:0] v;
      // directed corners
      add_point(0, 0);
      add_point(32767, 0);
      add_point(-32768, 0);
      add_point(-32767, 0);
      add_point(0, 32767);
      add_point(0, -32768);
      add_point(-32768, -32768);
      add_point(32767, 32767);
      add_point(-32768, 32767);
      add_point(32767, -32768);
      add_point(1, 0);
      add_point(-1, 0);
      add_point(0, 1);
      add_point(0, -1);
      add_point(1, 1);
      add_point(-1, 1);
      add_point(-1, -1);
      add_point(1, -1);
      add_point(-32768, 1);
      add_point(-32768, -1);
      add_point(-5, 0);
      add_point(100, -100);
      add_point(-16'sh5555, 16'sh2AAA);
      for (int n = 0; n < 1250; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_point(rand_coord(), rand_coord());
            4: add_point(small_coord(), small_coord());
            5: begin
               if ($urandom_range(0, 1)) add_point(rand_coord(), 0);
               else add_point(0, rand_coord());
            end
            6: add_point(edge_coord(), edge_coord());
            7: begin
               v = rand_coord();
               if (v == -32768) v = 32767;
               add_point($urandom_range(0, 1) ? v : -v, $urandom_range(0, 1) ? v : -v);
            end
            default: add_point(rand_coord(), small_coord());
         endcase
      end
      total_words = points_pending.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (words_in == total_words);
      wait (words_out == words_in);
      repeat (40) @(posedge clock);
      if (errors == 0 && polar_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #3200000;
      $display("FAILURE");
      $finish;
   end

endmodule
